### rtl/core/pixel_coordinate_rotator_assert.svh
// assertion macros for the coordinate rotator
// both sample on the rising edge of clock and stay quiet while reset is high
`ifndef PIXEL_COORDINATE_ROTATOR_ASSERT_SVH
`define PIXEL_COORDINATE_ROTATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PCR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcr same-cycle assertion failed");

// consequent checked in the cycle after the antecedent
`define PCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcr next-cycle assertion failed");

`endif

### rtl/core/pcr_pkg.sv
`timescale 1ns / 1ps

package pcr_pkg;

   // field widths
   localparam int SRC_W   = 10;
   localparam int PIX_W   = 32;
   localparam int CFG_W   = 11;
   localparam int DEG_W   = 9;
   localparam int TGT_W   = 12;
   localparam int ADDR_W  = 20;
   localparam int CSR_IDX_W = 3;

   // defaults for the top level parameters
   localparam int COORD_BITS     = 10;
   localparam int TRIG_FRAC_BITS = 16;

   // centered coordinate in half-pixel units
   localparam int CX_W = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION      = 3'd4;

   // register reset values
   localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH   = 11'd256;
   localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT  = 11'd256;
   localparam logic [CFG_W-1:0] RST_WINDOW_WIDTH  = 11'd320;
   localparam logic [CFG_W-1:0] RST_WINDOW_HEIGHT = 11'd240;
   localparam logic [DEG_W-1:0] RST_ROTATION      = 9'd0;

   // sine table covers 0..90 degrees
   localparam int SIN_ENTRIES = 91;
   localparam int SIN_IDX_W   = 7;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] DEG_STEP_Q = PI_Q60 / 180;
   localparam logic [63:0] DEG_STEP_R = PI_Q60 % 180;

   // sin(k degrees) in unsigned Q1.frac, from a Q60 taylor series, rounded
   // to nearest; only evaluated on constants
   function automatic logic [31:0] sin_fixed(input int unsigned k, input int unsigned frac);
      logic [63:0]         x;
      logic [63:0]         x2;
      logic [63:0]         term;
      logic [63:0]         v;
      logic [63:0]         rnd;
      logic signed [63:0]  sum;
      logic [127:0]        prod;
      int unsigned         i;
      x    = DEG_STEP_Q * 64'(k) + (DEG_STEP_R * 64'(k)) / 180;
      prod = {64'd0, x} * {64'd0, x};
      x2   = prod[123:60];
      term = x;
      sum  = $signed(x);
      for (i = 1; i <= 12; i++) begin
         prod = {64'd0, term} * {64'd0, x2};
         term = prod[123:60] / 64'((2 * i) * (2 * i + 1));
         if (i[0]) sum = sum - $signed(term);
         else      sum = sum + $signed(term);
      end
      v   = (sum < 0) ? 64'd0 : 64'(sum);
      rnd = (v + (64'd1 << (59 - frac))) >> (60 - frac);
      return 32'(rnd);
   endfunction

endpackage

### rtl/core/pcr_req_if.sv
`timescale 1ns / 1ps

interface pcr_req_if;
   logic                       valid;
   logic                       ready;
   logic [pcr_pkg::SRC_W-1:0]  source_x;
   logic [pcr_pkg::SRC_W-1:0]  source_y;
   logic [pcr_pkg::PIX_W-1:0]  pixel_value;

   modport source (output valid, source_x, source_y, pixel_value, input ready);
   modport sink   (input valid, source_x, source_y, pixel_value, output ready);
endinterface

### rtl/core/pcr_rsp_if.sv
`timescale 1ns / 1ps

interface pcr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [pcr_pkg::TGT_W-1:0] target_x;
   logic signed [pcr_pkg::TGT_W-1:0] target_y;
   logic                        inside_window;
   logic [pcr_pkg::ADDR_W-1:0]  target_address;
   logic [pcr_pkg::PIX_W-1:0]   pixel_out;

   modport source (output valid, target_x, target_y, inside_window, target_address,
                   pixel_out, input ready);
   modport sink   (input valid, target_x, target_y, inside_window, target_address,
                   pixel_out, output ready);
endinterface

### rtl/core/pixel_coordinate_rotator.sv
// pixel coordinate rotator: forward-maps source pixels onto a rotated frame
// req_chan carries one source pixel per transaction (column, row, color);
// rsp_chan returns its rotated column and row, an inside-window flag, the
// frame-buffer address row*window_width+column (zero when outside) and the
// color unchanged. csr_we/csr_index/csr_data write image size, window size
// and angle in degrees; write them only while no transaction is in flight.
// five register stages: input/centering, trig lookup, products, sum and
// rounding, bounds/address/output. a result reaches rsp_chan through these
// stages in order; one transaction is taken every cycle while the receiver
// keeps up, and the single product stage holds all four multipliers.
// each stage holds its own valid bit; a stage loads when it is empty or the
// one after it moves, so a stalled receiver backs up the pipe stage by
// stage without dropping or duplicating a transaction, and req_chan.ready
// falls only once all five stages are full.
// reset (synchronous) empties the pipe and restores register defaults:
// image 256x256, window 320x240, angle zero. the sine table is constant.
`timescale 1ns / 1ps
`include "pixel_coordinate_rotator_assert.svh"

module pixel_coordinate_rotator #(
   parameter int COORD_BITS     = pcr_pkg::COORD_BITS,
   parameter int TRIG_FRAC_BITS = pcr_pkg::TRIG_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   pcr_req_if.sink                           req_chan,
   pcr_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [pcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcr_pkg::CFG_W-1:0]         csr_data
);

   localparam int SRC_W = pcr_pkg::SRC_W;
   localparam int CFG_W = pcr_pkg::CFG_W;
   localparam int DEG_W = pcr_pkg::DEG_W;
   localparam int PIX_W = pcr_pkg::PIX_W;
   localparam int TGT_W = pcr_pkg::TGT_W;
   localparam int ADDR_W = pcr_pkg::ADDR_W;
   localparam int CXW   = pcr_pkg::CX_W;
   localparam int RW    = pcr_pkg::SIN_IDX_W;
   localparam int MW    = TRIG_FRAC_BITS + 1;     // trig magnitude
   localparam int TW    = TRIG_FRAC_BITS + 2;     // signed trig
   localparam int PW    = CXW + TW;               // one product
   localparam int NW    = PW + 2;                 // sum of two products and offset
   localparam int TXW   = NW - TRIG_FRAC_BITS;    // rounded target

   localparam logic [SRC_W-1:0] CMASK = SRC_W'((64'd1 << COORD_BITS) - 64'd1);
   localparam logic [NW-1:0]    HALF  = NW'(64'd1 << TRIG_FRAC_BITS);
   localparam logic signed [TXW-1:0] SAT_HI = TXW'((1 << (TGT_W - 1)) - 1);
   localparam logic signed [TXW-1:0] SAT_LO = -TXW'(1 << (TGT_W - 1));

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [CFG_W-1:0] image_width_ff;
   logic [CFG_W-1:0] image_height_ff;
   logic [CFG_W-1:0] window_width_ff;
   logic [CFG_W-1:0] window_height_ff;
   logic [DEG_W-1:0] rotation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= pcr_pkg::RST_IMAGE_WIDTH;
         image_height_ff  <= pcr_pkg::RST_IMAGE_HEIGHT;
         window_width_ff  <= pcr_pkg::RST_WINDOW_WIDTH;
         window_height_ff <= pcr_pkg::RST_WINDOW_HEIGHT;
         rotation_ff      <= pcr_pkg::RST_ROTATION;
      end else if (csr_we) begin
         unique case (csr_index)
            pcr_pkg::REG_IMAGE_WIDTH:   image_width_ff   <= csr_data;
            pcr_pkg::REG_IMAGE_HEIGHT:  image_height_ff  <= csr_data;
            pcr_pkg::REG_WINDOW_WIDTH:  window_width_ff  <= csr_data;
            pcr_pkg::REG_WINDOW_HEIGHT: window_height_ff <= csr_data;
            pcr_pkg::REG_ROTATION:      rotation_ff      <= csr_data[DEG_W-1:0];
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   // sine table 0..90 degrees, constant
   logic [MW-1:0] sin_rom [pcr_pkg::SIN_ENTRIES];
   for (genvar k = 0; k < pcr_pkg::SIN_ENTRIES; k++) begin : g_sin
      assign sin_rom[k] = MW'(pcr_pkg::sin_fixed(k, TRIG_FRAC_BITS));
   end

   // ---------------------------------------------------------------
   // pipeline advance: a stage loads when empty or when its successor moves
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5 = !v5_ff || rsp_chan.ready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_chan.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_chan.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: center coordinates in half-pixel units, angle to quadrant
   // ---------------------------------------------------------------
   logic [SRC_W-1:0]        sx_msk, sy_msk;
   logic signed [CXW-1:0]   cx1_in, cy1_in;
   logic [DEG_W-1:0]        deg_red;
   logic [1:0]              quad1_in;
   logic [DEG_W-1:0]        quad_base;
   logic [RW-1:0]           rem1_in;

   logic signed [CXW-1:0]   cx1_ff, cy1_ff;
   logic [1:0]              quad1_ff;
   logic [RW-1:0]           rem1_ff;
   logic [PIX_W-1:0]        pix1_ff;

   always_comb begin
      sx_msk = req_chan.source_x & CMASK;
      sy_msk = req_chan.source_y & CMASK;
      cx1_in = $signed(CXW'({sx_msk, 1'b1})) - $signed(CXW'(image_width_ff));
      cy1_in = $signed(CXW'({sy_msk, 1'b1})) - $signed(CXW'(image_height_ff));
      // register holds up to 511, one fold brings it under 360
      deg_red = (rotation_ff >= 9'd360) ? rotation_ff - 9'd360 : rotation_ff;
      if (deg_red >= 9'd270) begin
         quad1_in  = QUAD_3;
         quad_base = 9'd270;
      end else if (deg_red >= 9'd180) begin
         quad1_in  = QUAD_2;
         quad_base = 9'd180;
      end else if (deg_red >= 9'd90) begin
         quad1_in  = QUAD_1;
         quad_base = 9'd90;
      end else begin
         quad1_in  = QUAD_0;
         quad_base = 9'd0;
      end
      rem1_in = RW'(deg_red - quad_base);
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         cx1_ff   <= cx1_in;
         cy1_ff   <= cy1_in;
         quad1_ff <= quad1_in;
         rem1_ff  <= rem1_in;
         pix1_ff  <= req_chan.pixel_value;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: table lookup and quadrant symmetry
   // ---------------------------------------------------------------
   logic signed [TW-1:0] sin_a, sin_b;
   logic signed [TW-1:0] s2_in, c2_in;
   logic signed [TW-1:0] s2_ff, c2_ff;
   logic signed [CXW-1:0] cx2_ff, cy2_ff;
   logic [PIX_W-1:0]     pix2_ff;

   always_comb begin
      sin_a = $signed({1'b0, sin_rom[rem1_ff]});
      sin_b = $signed({1'b0, sin_rom[RW'(7'd90 - rem1_ff)]});
      case (quad1_ff)
         QUAD_0: begin
            s2_in = sin_a;
            c2_in = sin_b;
         end
         QUAD_1: begin
            s2_in = sin_b;
            c2_in = -sin_a;
         end
         QUAD_2: begin
            s2_in = -sin_a;
            c2_in = -sin_b;
         end
         default: begin
            s2_in = -sin_b;
            c2_in = sin_a;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_ff   <= s2_in;
         c2_ff   <= c2_in;
         cx2_ff  <= cx1_ff;
         cy2_ff  <= cy1_ff;
         pix2_ff <= pix1_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: the four rotation products
   // ---------------------------------------------------------------
   logic signed [PW-1:0] cx_e, cy_e, s_e, c_e;
   logic signed [PW-1:0] pxc3_ff, pys3_ff, pxs3_ff, pyc3_ff;
   logic [PIX_W-1:0]     pix3_ff;

   assign cx_e = PW'(cx2_ff);
   assign cy_e = PW'(cy2_ff);
   assign s_e  = PW'(s2_ff);
   assign c_e  = PW'(c2_ff);

   always_ff @(posedge clock) begin
      if (adv3) begin
         pxc3_ff <= cx_e * c_e;
         pys3_ff <= cy_e * s_e;
         pxs3_ff <= cx_e * s_e;
         pyc3_ff <= cy_e * c_e;
         pix3_ff <= pix2_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: sum, shift back to pixel grid, round half away from zero
   // ---------------------------------------------------------------
   function automatic logic signed [TXW-1:0] round_away(input logic signed [NW-1:0] n);
      logic [NW-1:0] mag;
      logic [NW-1:0] qm;
      mag = (n > 0) ? NW'(n) : NW'(-n);
      qm  = (mag + HALF) >> (TRIG_FRAC_BITS + 1);
      return (n > 0) ? $signed(TXW'(qm)) : -$signed(TXW'(qm));
   endfunction

   logic signed [NW-1:0]  off_x, off_y;
   logic signed [NW-1:0]  nx, ny;
   logic signed [TXW-1:0] tx4_ff, ty4_ff;
   logic [PIX_W-1:0]      pix4_ff;

   always_comb begin
      off_x = $signed(NW'(image_width_ff) - NW'(1)) <<< TRIG_FRAC_BITS;
      off_y = $signed(NW'(image_height_ff) - NW'(1)) <<< TRIG_FRAC_BITS;
      nx = NW'(pxc3_ff) - NW'(pys3_ff) + off_x;
      ny = NW'(pxs3_ff) + NW'(pyc3_ff) + off_y;
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         tx4_ff  <= round_away(nx);
         ty4_ff  <= round_away(ny);
         pix4_ff <= pix3_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: window check, saturation, frame-buffer address
   // ---------------------------------------------------------------
   logic                    inside5_in;
   logic signed [TGT_W-1:0] tx5_in, ty5_in;
   logic [2*CFG_W-1:0]      row_base;
   logic [ADDR_W-1:0]       addr5_in;

   logic signed [TGT_W-1:0] tx5_ff, ty5_ff;
   logic                    inside5_ff;
   logic [ADDR_W-1:0]       addr5_ff;
   logic [PIX_W-1:0]        pix5_ff;

   always_comb begin
      // judged on the unsaturated target
      inside5_in = (tx4_ff >= 0) && (tx4_ff < $signed(TXW'(window_width_ff))) &&
                   (ty4_ff >= 0) && (ty4_ff < $signed(TXW'(window_height_ff)));
      tx5_in = (tx4_ff > SAT_HI) ? TGT_W'(SAT_HI) :
               (tx4_ff < SAT_LO) ? TGT_W'(SAT_LO) : TGT_W'(tx4_ff);
      ty5_in = (ty4_ff > SAT_HI) ? TGT_W'(SAT_HI) :
               (ty4_ff < SAT_LO) ? TGT_W'(SAT_LO) : TGT_W'(ty4_ff);
      row_base = ty4_ff[CFG_W-1:0] * window_width_ff;
      addr5_in = inside5_in ?
                 ADDR_W'(row_base + (2*CFG_W)'(tx4_ff[CFG_W-1:0])) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         tx5_ff     <= tx5_in;
         ty5_ff     <= ty5_in;
         inside5_ff <= inside5_in;
         addr5_ff   <= addr5_in;
         pix5_ff    <= pix4_ff;
      end
   end

   assign rsp_chan.valid          = v5_ff;
   assign rsp_chan.target_x       = tx5_ff;
   assign rsp_chan.target_y       = ty5_ff;
   assign rsp_chan.inside_window  = inside5_ff;
   assign rsp_chan.target_address = addr5_ff;
   assign rsp_chan.pixel_out      = pix5_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // an accepted transaction always lands in the first stage
   `PCR_ASSERT_NEXT(a_accept_loads, req_chan.valid && req_chan.ready, v1_ff)
   // a full rounding stage that moves hands its transaction to the output
   `PCR_ASSERT_NEXT(a_stage_handoff, v4_ff && adv5, v5_ff)
   // an inside target has non-negative coordinates below the window width
   `PCR_ASSERT_SAME(a_inside_bounds, rsp_chan.valid && rsp_chan.inside_window,
                    !rsp_chan.target_x[TGT_W-1] && !rsp_chan.target_y[TGT_W-1] &&
                    ($unsigned(rsp_chan.target_x) < TGT_W'(window_width_ff)))
   // outside targets carry a zero address
   `PCR_ASSERT_SAME(a_outside_addr, rsp_chan.valid && !rsp_chan.inside_window, rsp_chan.target_address == '0)

endmodule

### dv/pixel_coordinate_rotator_tb.sv
`timescale 1ns / 1ps

module pixel_coordinate_rotator_tb;
   import pcr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
   localparam int HOLD_CYCLES = 120;     // long receiver hold-off, fills the pipe
   localparam int DRAIN_TAIL  = 10;      // five stages plus margin
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 110;

   // one rotated pixel as the block reports it
   typedef struct {
      logic signed [TGT_W-1:0] target_x;
      logic signed [TGT_W-1:0] target_y;
      logic                    inside_window;
      logic [ADDR_W-1:0]       target_address;
      logic [PIX_W-1:0]        pixel_out;
   } placement_type;

   // predicts where each accepted pixel lands and checks the block's answers in order
   class rotation_scoreboard;
      logic [CFG_W-1:0] img_w;
      logic [CFG_W-1:0] img_h;
      logic [CFG_W-1:0] win_w;
      logic [CFG_W-1:0] win_h;
      logic [DEG_W-1:0] angle;
      longint           sine_lut [0:90];
      placement_type    pending_placements [$];
      int               errors;

      function new();
         for (int k = 0; k <= 90; k++) sine_lut[k] = sine_entry(k);
         img_w  = RST_IMAGE_WIDTH;
         img_h  = RST_IMAGE_HEIGHT;
         win_w  = RST_WINDOW_WIDTH;
         win_h  = RST_WINDOW_HEIGHT;
         angle  = RST_ROTATION;
         errors = 0;
      endfunction

      // (a*b) >> 60 on q60 operands
      function longint unsigned q60_product(longint unsigned a, longint unsigned b);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         return p[123:60];
      endfunction

      // sin of whole degrees 0..90 in q1.frac, taylor series in q60 then rounded
      function longint sine_entry(int unsigned deg);
         longint unsigned arg;
         longint unsigned arg_sq;
         longint unsigned term;
         longint          acc;
         arg    = (PI_Q60 / 180) * 64'(deg) + ((PI_Q60 % 180) * 64'(deg)) / 180;
         arg_sq = q60_product(arg, arg);
         term   = arg;
         acc    = longint'(arg);
         for (int n = 1; n <= 12; n++) begin
            term = q60_product(term, arg_sq) / 64'((2 * n) * (2 * n + 1));
            if (n % 2) acc -= longint'(term);
            else acc += longint'(term);
         end
         if (acc < 0) acc = 0;
         return (acc + (longint'(1) << (59 - TRIG_FRAC_BITS))) >>> (60 - TRIG_FRAC_BITS);
      endfunction

      // divide by 2^(frac+1), rounding half away from zero
      function longint half_away(longint n);
         longint half;
         half = longint'(1) << TRIG_FRAC_BITS;
         if (n > 0) return (n + half) >>> (TRIG_FRAC_BITS + 1);
         return -((-n + half) >>> (TRIG_FRAC_BITS + 1));
      endfunction

      function logic signed [TGT_W-1:0] clamp_target(longint v);
         longint lo;
         longint hi;
         lo = -(longint'(1) << (TGT_W - 1));
         hi = -lo - 1;
         if (v < lo) return TGT_W'(lo);
         if (v > hi) return TGT_W'(hi);
         return TGT_W'(v);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            REG_IMAGE_WIDTH: begin
               img_w = data;
            end
            REG_IMAGE_HEIGHT: begin
               img_h = data;
            end
            REG_WINDOW_WIDTH: begin
               win_w = data;
            end
            REG_WINDOW_HEIGHT: begin
               win_h = data;
            end
            REG_ROTATION: begin
               angle = data[DEG_W-1:0];
            end
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [SRC_W-1:0] sx, logic [SRC_W-1:0] sy,
                               logic [PIX_W-1:0] pix);
         longint        cx;
         longint        cy;
         longint        sn;
         longint        cs;
         longint        rx;
         longint        ry;
         longint        unit;
         longint        cmask;
         int unsigned   turn;
         int unsigned   rem;
         bit            hit;
         placement_type p;
         cmask = (longint'(1) << COORD_BITS) - 1;
         unit  = longint'(1) << TRIG_FRAC_BITS;
         cx    = 2 * (longint'(sx) & cmask) + 1 - longint'(img_w);
         cy    = 2 * (longint'(sy) & cmask) + 1 - longint'(img_h);
         turn  = angle % 360;
         rem   = turn % 90;
         // quadrant symmetry from the 0..90 table
         case (turn / 90)
            0: begin
               sn = sine_lut[rem];
               cs = sine_lut[90 - rem];
            end
            1: begin
               sn = sine_lut[90 - rem];
               cs = -sine_lut[rem];
            end
            2: begin
               sn = -sine_lut[rem];
               cs = -sine_lut[90 - rem];
            end
            default: begin
               sn = -sine_lut[90 - rem];
               cs = sine_lut[rem];
            end
         endcase
         rx  = half_away(cx * cs - cy * sn + (longint'(img_w) - 1) * unit);
         ry  = half_away(cx * sn + cy * cs + (longint'(img_h) - 1) * unit);
         hit = rx >= 0 && rx < longint'(win_w) && ry >= 0 && ry < longint'(win_h);
         p.target_x       = clamp_target(rx);
         p.target_y       = clamp_target(ry);
         p.inside_window  = hit;
         p.target_address = hit ? ADDR_W'(ry * longint'(win_w) + rx) : '0;
         p.pixel_out      = pix;
         pending_placements.push_back(p);
      endfunction

      function void check_placement(placement_type got);
         placement_type want;
         if (pending_placements.size() == 0) begin
            $error("result with no pixel outstanding: target_x %0d target_y %0d",
                   got.target_x, got.target_y);
            errors++;
            return;
         end
         want = pending_placements.pop_front();
         if (got.target_x !== want.target_x) begin
            $error("target_x: expected %0d, actual %0d", want.target_x, got.target_x);
            errors++;
         end
         if (got.target_y !== want.target_y) begin
            $error("target_y: expected %0d, actual %0d", want.target_y, got.target_y);
            errors++;
         end
         if (got.inside_window !== want.inside_window) begin
            $error("inside_window: expected %0b, actual %0b",
                   want.inside_window, got.inside_window);
            errors++;
         end
         if (got.target_address !== want.target_address) begin
            $error("target_address: expected %0d, actual %0d",
                   want.target_address, got.target_address);
            errors++;
         end
         if (got.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %08h, actual %08h", want.pixel_out, got.pixel_out);
            errors++;
         end
      endfunction

      function int pending();
         return pending_placements.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   // idling switches random gaps on both sides; hold_off_req asks the
   // receiver for one long stall
   bit                   idling;
   bit                   hold_off_req;
   int                   cycle_count;

   rotation_scoreboard   board;

   pcr_req_if req_chan ();
   pcr_rsp_if rsp_chan ();

   pixel_coordinate_rotator uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 4 ns period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // offer one pixel, maybe after a short gap, and return at the accepting edge
   task automatic send_pixel(input logic [SRC_W-1:0] sx, input logic [SRC_W-1:0] sy,
                             input logic [PIX_W-1:0] pix);
      int gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.source_x    <= sx;
      req_chan.source_y    <= sy;
      req_chan.pixel_value <= pix;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // stop offering and wait until every outstanding transaction has come back
   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // registers only change with the pipe empty
   task automatic apply_setting(input logic [CFG_W-1:0] iw, input logic [CFG_W-1:0] ih,
                                input logic [CFG_W-1:0] ww, input logic [CFG_W-1:0] wh,
                                input logic [DEG_W-1:0] deg);
      logic [CFG_W-1:0]     vals [5];
      logic [CSR_IDX_W-1:0] regs [5];
      vals = '{iw, ih, ww, wh, CFG_W'(deg)};
      regs = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT,
               REG_ROTATION};
      pause_until_drained();
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // mostly in-range sizes, with zero, one, the nominal top and over-range values
   function automatic logic [CFG_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CFG_W'(1);
         2: return CFG_W'(1024);
         3: return CFG_W'($urandom_range(1025, 2047));
         4: return CFG_W'(2047);
         default: return CFG_W'($urandom_range(1, 1024));
      endcase
   endfunction

   function automatic logic [DEG_W-1:0] pick_angle();
      case ($urandom_range(0, 9))
         5: return DEG_W'(90 * $urandom_range(0, 5));
         6: return DEG_W'($urandom_range(360, 511));
         7: return '0;
         8: return DEG_W'(359);
         default: return DEG_W'($urandom_range(0, 359));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // one configuration, then a stream of pixels mostly from inside the image
   task automatic random_phase(input int phase, input int count);
      logic [CFG_W-1:0] iw;
      logic [CFG_W-1:0] ih;
      logic [CFG_W-1:0] ww;
      logic [CFG_W-1:0] wh;
      logic [DEG_W-1:0] deg;
      logic [SRC_W-1:0] sx;
      logic [SRC_W-1:0] sy;
      int               span_x;
      int               span_y;
      case (phase)
         0: begin
            iw = 1; ih = 1; ww = 1; wh = 1; deg = 0;
         end
         1: begin
            iw = 1024; ih = 1024; ww = 1024; wh = 1024; deg = 359;
         end
         2: begin
            iw = 2047; ih = 2047; ww = 2047; wh = 2047; deg = 511;
         end
         default: begin
            iw  = pick_size();
            ih  = pick_size();
            deg = pick_angle();
            // usually a window a bit larger than the image so many targets land inside
            if ($urandom_range(0, 4) < 3) begin
               ww = (iw > 1983) ? iw : iw + CFG_W'($urandom_range(0, 64));
               wh = (ih > 1983) ? ih : ih + CFG_W'($urandom_range(0, 64));
            end else begin
               ww = pick_size();
               wh = pick_size();
            end
         end
      endcase
      apply_setting(iw, ih, ww, wh, deg);
      // every fourth phase and the closing phases run without gaps
      idling = !(phase % 4 == 2 || phase >= PHASES - 2);
      // one long receiver stall while pixels keep coming
      if (phase == 3) hold_off_req = 1'b1;
      span_x = (iw == 0 || iw > 1024) ? 1024 : iw;
      span_y = (ih == 0 || ih > 1024) ? 1024 : ih;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 4) != 0) begin
            sx = SRC_W'($urandom_range(0, span_x - 1));
            sy = SRC_W'($urandom_range(0, span_y - 1));
         end else begin
            sx = SRC_W'($urandom_range(0, 1023));
            sy = SRC_W'($urandom_range(0, 1023));
         end
         if (phase == 5 && k == count / 2) pause_until_drained();
         send_pixel(sx, sy, pick_pixel());
      end
   endtask

   // receiver: ready with random short stalls, plus the long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // monitor: register writes, accepted pixels and returned placements, all
   // sampled at the rising edge before anything driven there takes effect
   always @(posedge clock) begin
      placement_type seen;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else if (!reset) begin
         if (csr_we) board.write_reg(csr_index, csr_data);
         if (req_chan.valid && req_chan.ready)
            board.note_pixel(req_chan.source_x, req_chan.source_y, req_chan.pixel_value);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.target_x       = rsp_chan.target_x;
            seen.target_y       = rsp_chan.target_y;
            seen.inside_window  = rsp_chan.inside_window;
            seen.target_address = rsp_chan.target_address;
            seen.pixel_out      = rsp_chan.pixel_out;
            board.check_placement(seen);
         end
      end
   end

   initial begin
      board        = new();
      cycle_count  = 0;
      idling       = 1'b0;
      hold_off_req = 1'b0;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= REG_IMAGE_WIDTH;
      csr_data             <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.source_x    <= '0;
      req_chan.source_y    <= '0;
      req_chan.pixel_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: image corners, a pixel far outside the image, color extremes and patterns
      send_pixel(10'd0, 10'd0, 32'h0000_0000);
      send_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF);
      send_pixel(10'd255, 10'd0, 32'hA5A5_A5A5);
      send_pixel(10'd0, 10'd255, 32'h5A5A_5A5A);

      // each quadrant
      apply_setting(11'd64, 11'd48, 11'd64, 11'd48, 9'd90);
      send_pixel(10'd0, 10'd0, 32'h0000_0001);
      send_pixel(10'd63, 10'd47, 32'h8000_0000);
      apply_setting(11'd64, 11'd48, 11'd64, 11'd48, 9'd180);
      send_pixel(10'd10, 10'd20, 32'h1234_5678);
      send_pixel(10'd63, 10'd0, 32'h8765_4321);
      apply_setting(11'd100, 11'd50, 11'd100, 11'd100, 9'd270);
      send_pixel(10'd0, 10'd49, 32'h0F0F_0F0F);
      send_pixel(10'd99, 10'd0, 32'hF0F0_F0F0);

      // angle past a full turn with a zero-width window: never inside
      apply_setting(11'd64, 11'd64, 11'd0, 11'd64, 9'd450);
      send_pixel(10'd5, 10'd5, 32'h0000_FFFF);
      send_pixel(10'd32, 10'd32, 32'hFFFF_0000);

      // largest angle register value
      apply_setting(11'd200, 11'd100, 11'd320, 11'd240, 9'd511);
      send_pixel(10'd0, 10'd0, 32'h3C3C_3C3C);
      send_pixel(10'd199, 10'd99, 32'hC3C3_C3C3);

      // oversized image at 135 degrees pushes target_x past the field range
      apply_setting(11'd2047, 11'd2047, 11'd1024, 11'd1024, 9'd135);
      send_pixel(10'd0, 10'd0, 32'h7FFF_FFFF);
      send_pixel(10'd0, 10'd1023, 32'hDEAD_0001);

      // oversized window: row times pitch wraps past 20 bits
      apply_setting(11'd1024, 11'd1024, 11'd2047, 11'd2047, 9'd0);
      send_pixel(10'd1023, 10'd1023, 32'h0101_0101);
      send_pixel(10'd512, 10'd1000, 32'hFEFE_FEFE);

      // zero image size keeps the same arithmetic
      apply_setting(11'd0, 11'd0, 11'd16, 11'd16, 9'd30);
      send_pixel(10'd0, 10'd0, 32'h5555_5555);
      send_pixel(10'd7, 10'd3, 32'hAAAA_AAAA);

      for (int phase = 0; phase < PHASES; phase++) random_phase(phase, PHASE_ITEMS);

      pause_until_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### pixel_coordinate_rotator.f
+incdir+rtl/core
rtl/core/pcr_pkg.sv
rtl/core/pcr_req_if.sv
rtl/core/pcr_rsp_if.sv
rtl/core/pixel_coordinate_rotator.sv
dv/pixel_coordinate_rotator_tb.sv
